// ===== rtl/roo_pkg.sv =====
// roo_pkg: request and result types plus single-precision multiply, add and
// rounding helpers shared by the ray origin offset pipeline.
// No dependencies.
`default_nettype none
package roo_pkg;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] FP_TWO  = 32'h4000_0000;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF = 32'hFF80_0000;
  localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [31:0] err_x;
    logic [31:0] err_y;
    logic [31:0] err_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
  } in_req_t;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
  } out_req_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:0] == 31'h7F80_0000);
  endfunction

  // Count leading zeros of a 50-bit significand
  function automatic logic [5:0] lzc(input logic [49:0] m);
    logic [5:0] n;
    logic found;
    n = 6'd50;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found && m[i]) begin
        n = 6'(49 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack; m has its leading one at bit 49
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                           input logic [49:0] m);
    logic [49:0] m2;
    logic [49:0] mask;
    logic [11:0] sh;
    logic stk;
    logic up;
    logic [7:0] ef;
    logic [30:0] mag;
    m2 = m;
    mask = '0;
    sh = '0;
    stk = 1'b0;
    ef = '0;
    if (m == 50'd0) return {sgn, 31'd0};
    if (e >= 12'sd255) return {sgn, 8'hFF, 23'd0};
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      if (sh >= 12'd50) begin
        stk = |m;
        m2 = '0;
      end else begin
        mask = (50'd1 << sh) - 50'd1;
        stk = |(m & mask);
        m2 = m >> sh;
      end
      ef = 8'd0;
    end else begin
      ef = e[7:0];
    end
    stk = stk | (|m2[24:0]);
    up = m2[25] & (stk | m2[26]);
    mag = {ef, m2[48:26]} + 31'(up);
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    logic za, zb;
    logic [23:0] ma, mb;
    logic signed [11:0] xa, xb, e;
    logic [47:0] p;
    logic [49:0] m;
    logic [5:0] lz;
    s = a[31] ^ b[31];
    za = (a[30:0] == 31'd0);
    zb = (b[30:0] == 31'd0);
    if (is_nan(a) || is_nan(b) || (is_inf(a) && zb) || (za && is_inf(b))) return QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (za || zb) return {s, 31'd0};
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    xa = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]});
    xb = $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]});
    p = ma * mb;
    m = {p, 2'b00};
    lz = lzc(m);
    m = m << lz;
    e = xa + xb - 12'sd126 - $signed({6'd0, lz});
    return fp_round(s, e, m);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml;
    logic [11:0] xb, xs, d;
    logic [49:0] mb, ms, mask, sum;
    logic stk;
    logic [5:0] lz;
    logic signed [11:0] e;
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    xb = {4'd0, (big[30:23] == 8'd0) ? 8'd1 : big[30:23]};
    xs = {4'd0, (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23]};
    d = xb - xs;
    mb = {1'b0, |big[30:23], big[22:0], 25'd0};
    ms = {1'b0, |sml[30:23], sml[22:0], 25'd0};
    mask = '0;
    // align the smaller operand, folding lost bits into a sticky bit
    if (d >= 12'd50) begin
      stk = |ms;
      ms = '0;
    end else begin
      mask = (50'd1 << d) - 50'd1;
      stk = |(ms & mask);
      ms = ms >> d;
    end
    ms[0] = ms[0] | stk;
    if (a[31] == b[31]) sum = mb + ms;
    else sum = mb - ms;
    if (sum == 50'd0) return {a[31] & b[31], 31'd0};
    lz = lzc(sum);
    sum = sum << lz;
    e = $signed(xb) + 12'sd1 - $signed({6'd0, lz});
    return fp_round(big[31], e, sum);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/roo_prod_lane.sv =====
// roo_prod_lane: one axis of the first stage; registers |n|*e and n*d.
// Depends on roo_pkg.
`default_nettype none
module roo_prod_lane (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] norm,
  input  wire logic [31:0] err,
  input  wire logic [31:0] dir,
  output logic [31:0]      err_prod_r,
  output logic [31:0]      dir_prod_r
);

  logic [31:0] err_prod_nxt;
  logic [31:0] dir_prod_nxt;

  // form both products of this axis
  always_comb begin
    err_prod_nxt = roo_pkg::fp_mul({1'b0, norm[30:0]}, err);
    dir_prod_nxt = roo_pkg::fp_mul(norm, dir);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_prod_r <= err_prod_nxt;
      dir_prod_r <= dir_prod_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/roo_merge.sv =====
// roo_merge: sums the lane products left to right, scales the distance by
// two and decides the facing sign. Depends on roo_pkg.
`default_nettype none
module roo_merge (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] err_prod [3],
  input  wire logic [31:0] dir_prod [3],
  output logic [31:0]      dist_r,
  output logic             flip_r
);

  logic [31:0] esum1_r, esum1_nxt, dsum1_r, dsum1_nxt;
  logic [31:0] esum2_r, esum2_nxt, dsum2_r, dsum2_nxt;
  logic [31:0] e2_r, d2_r;
  logic [31:0] dist_nxt;
  logic        flip_nxt;

  // first partial sums, then the third term, then scale and test
  always_comb begin
    esum1_nxt = roo_pkg::fp_add(err_prod[0], err_prod[1]);
    dsum1_nxt = roo_pkg::fp_add(dir_prod[0], dir_prod[1]);
    esum2_nxt = roo_pkg::fp_add(esum1_r, e2_r);
    dsum2_nxt = roo_pkg::fp_add(dsum1_r, d2_r);
    dist_nxt  = roo_pkg::fp_mul(roo_pkg::FP_TWO, esum2_r);
    flip_nxt  = !roo_pkg::is_nan(dsum2_r) && dsum2_r[31] && (dsum2_r[30:0] != 31'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      esum1_r <= esum1_nxt;
      dsum1_r <= dsum1_nxt;
      e2_r    <= err_prod[2];
      d2_r    <= dir_prod[2];
      esum2_r <= esum2_nxt;
      dsum2_r <= dsum2_nxt;
      dist_r  <= dist_nxt;
      flip_r  <= flip_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/roo_out_lane.sv =====
// roo_out_lane: one axis of the last two stages; scales the normal by the
// distance, adds it to the point and steps one float away. Depends on roo_pkg.
`default_nettype none
module roo_out_lane (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] distance,
  input  wire logic        flip,
  input  wire logic [31:0] norm,
  input  wire logic [31:0] point,
  output logic [31:0]      origin_r
);

  logic [31:0] off_r, off_nxt, point_r;
  logic [31:0] sum, origin_nxt, b;
  logic        pos, neg;

  // offset, negated when the normal faces away
  always_comb begin
    off_nxt = roo_pkg::fp_mul(distance, norm);
    if (flip) off_nxt[31] = ~off_nxt[31];
  end

  // add and step away from the surface
  always_comb begin
    sum = roo_pkg::fp_add(point_r, off_r);
    pos = !roo_pkg::is_nan(off_r) && !off_r[31] && (off_r[30:0] != 31'd0);
    neg = !roo_pkg::is_nan(off_r) && off_r[31] && (off_r[30:0] != 31'd0);
    b = sum;
    if (roo_pkg::is_nan(sum)) begin
      origin_nxt = roo_pkg::QNAN;
    end else if (pos) begin
      if (sum == roo_pkg::POS_INF) begin
        origin_nxt = sum;
      end else begin
        if (sum == roo_pkg::NEG_ZERO) b = 32'd0;
        origin_nxt = b[31] ? b - 32'd1 : b + 32'd1;
      end
    end else if (neg) begin
      if (sum == roo_pkg::NEG_INF) begin
        origin_nxt = sum;
      end else begin
        if (sum == 32'd0) b = roo_pkg::NEG_ZERO;
        origin_nxt = b[31] ? b + 32'd1 : b - 32'd1;
      end
    end else begin
      origin_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r    <= off_nxt;
      point_r  <= point;
      origin_r <= origin_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ray_origin_offset.sv =====
// ray_origin_offset: top level; three product lanes, a merging block and
// three output lanes. Depends on roo_pkg, roo_prod_lane, roo_merge, roo_out_lane.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request: point,
//   error bound, normal and direction as single-precision bit patterns.
//   Result channel out_valid / out_stall / out_data carries the offset
//   origin. A request moves at a clock edge with valid high and stall low.
//   One request is taken every cycle unless the pipeline is frozen. The depth
//   is set by the chain multiply, add, add, scale, multiply, add that each
//   request runs through, one float unit per stage.
//   When out_stall holds a waiting result the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is lost or duplicated.
//   Synchronous active-low reset empties the pipeline; data regs keep junk.
`default_nettype none
module ray_origin_offset (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire roo_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output roo_pkg::out_req_t      out_data
);

  localparam int Depth = 6;

  logic [Depth-1:0] vld_r, vld_nxt;
  logic             adv;
  logic [31:0]      pnt_in [3], nrm_in [3], err_in [3], dir_in [3];
  logic [31:0]      err_prod [3], dir_prod [3];
  logic [31:0]      pnt_r [4][3], nrm_r [4][3];
  logic [31:0]      origin [3];
  logic [31:0]      distance;
  logic             flip;

  // advance unless a finished result is held
  assign adv      = !(vld_r[Depth-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[Depth-1];
  assign out_data  = '{origin_x: origin[0], origin_y: origin[1], origin_z: origin[2]};

  assign pnt_in = '{in_data.point_x, in_data.point_y, in_data.point_z};
  assign err_in = '{in_data.err_x, in_data.err_y, in_data.err_z};
  assign nrm_in = '{in_data.norm_x, in_data.norm_y, in_data.norm_z};
  assign dir_in = '{in_data.dir_x, in_data.dir_y, in_data.dir_z};

  // shift the valid bits
  always_comb begin
    vld_nxt = {vld_r[Depth-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // delay point and normal to the output lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      pnt_r[0] <= pnt_in;
      nrm_r[0] <= nrm_in;
      for (int s = 1; s < 4; s++) begin
        pnt_r[s] <= pnt_r[s-1];
        nrm_r[s] <= nrm_r[s-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_prod
    roo_prod_lane u_prod (
      .clk        (clk),
      .en         (adv),
      .norm       (nrm_in[i]),
      .err        (err_in[i]),
      .dir        (dir_in[i]),
      .err_prod_r (err_prod[i]),
      .dir_prod_r (dir_prod[i])
    );
  end

  roo_merge u_merge (
    .clk      (clk),
    .en       (adv),
    .err_prod (err_prod),
    .dir_prod (dir_prod),
    .dist_r   (distance),
    .flip_r   (flip)
  );

  for (genvar i = 0; i < 3; i++) begin : g_out
    roo_out_lane u_out (
      .clk      (clk),
      .en       (adv),
      .distance (distance),
      .flip     (flip),
      .norm     (nrm_r[3][i]),
      .point    (pnt_r[3][i]),
      .origin_r (origin[i])
    );
  end

`ifndef SYNTH
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_qnan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && roo_pkg::is_nan(out_data.origin_x)) |-> out_data.origin_x == roo_pkg::QNAN)
    else $error("non-canonical NaN on origin_x");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[Depth-1] && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while the result was held");
`endif

endmodule
`default_nettype wire

// ===== sim/ray_origin_offset_test.sv =====
// Self-checking bench for ray_origin_offset: random and corner-case requests
// are scored against a bit-exact single-precision model. Uses roo_pkg types.
`timescale 1ns / 100ps
module ray_origin_offset_test;

  localparam logic [31:0] FLT_MAX = 32'h7F7F_FFFF;
  localparam logic [31:0] MIN_SUB = 32'h0000_0001;
  localparam logic [31:0] ONE_F   = 32'h3F80_0000;
  localparam logic [31:0] NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] SNAN    = 32'h7F80_0001;
  localparam int          N_RANDOM = 1800;

  // Expected-origin store with its own single-precision arithmetic
  class origin_board;
    roo_pkg::out_req_t pending[$];
    int       mismatches;

    static function automatic bit nan_bits(logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    static function automatic bit inf_bits(logic [31:0] a);
      return a[30:0] == 31'h7F80_0000;
    endfunction

    // Round mag * 2^x to nearest even and pack; mag is nonzero
    static function automatic logic [31:0] pack_rne(bit s, logic [63:0] mag, int x);
      int p, lsb, sh;
      logic [63:0] kept;
      bit rb, st;
      p = 63;
      while (!mag[p]) p--;
      lsb = (p + x - 23 > -149) ? p + x - 23 : -149;
      sh = lsb - x;
      rb = 0;
      st = 0;
      if (sh <= 0) begin
        kept = mag << (-sh);
      end else if (sh > 64) begin
        kept = 0;
        st = 1;
      end else begin
        kept = mag >> sh;
        rb = mag[sh-1];
        if (sh > 1) st = |(mag & ((64'd1 << (sh - 1)) - 1));
      end
      if (rb && (st || kept[0])) kept++;
      if (kept[24]) begin
        kept = kept >> 1;
        lsb++;
      end
      if (!kept[23]) return {s, 8'd0, kept[22:0]};
      if (lsb + 150 >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(lsb + 150), kept[22:0]};
    endfunction

    static function automatic logic [23:0] sig_of(logic [31:0] a);
      return {|a[30:23], a[22:0]};
    endfunction

    static function automatic int exp_of(logic [31:0] a);
      return (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    static function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      bit s;
      logic [63:0] mag;
      s = a[31] ^ b[31];
      if (nan_bits(a) || nan_bits(b)) return roo_pkg::QNAN;
      if ((inf_bits(a) && b[30:0] == 0) || (inf_bits(b) && a[30:0] == 0)) return roo_pkg::QNAN;
      if (inf_bits(a) || inf_bits(b)) return {s, 8'hFF, 23'd0};
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      mag = 64'(sig_of(a)) * 64'(sig_of(b));
      return pack_rne(s, mag, exp_of(a) + exp_of(b));
    endfunction

    static function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      logic [31:0] big, sml;
      logic [63:0] mb, ms, sum;
      int d, x;
      if (nan_bits(a) || nan_bits(b)) return roo_pkg::QNAN;
      if (inf_bits(a) && inf_bits(b) && a[31] != b[31]) return roo_pkg::QNAN;
      if (inf_bits(a)) return a;
      if (inf_bits(b)) return b;
      if (a[30:0] >= b[30:0]) begin
        big = a;
        sml = b;
      end else begin
        big = b;
        sml = a;
      end
      if (sml[30:0] == 0 && big[30:0] != 0) return big;
      d = exp_of(big) - exp_of(sml);
      // far-apart operands: small one only contributes a sticky bit
      if (d <= 40) begin
        mb = 64'(sig_of(big)) << d;
        ms = 64'(sig_of(sml));
        x = exp_of(sml);
      end else begin
        mb = 64'(sig_of(big)) << 3;
        ms = 64'd1;
        x = exp_of(big) - 3;
      end
      sum = (a[31] == b[31]) ? mb + ms : mb - ms;
      if (sum == 0) return {a[31] & b[31], 31'd0};
      return pack_rne(big[31], sum, x);
    endfunction

    static function automatic bit is_pos(logic [31:0] a);
      return !nan_bits(a) && a[30:0] != 0 && !a[31];
    endfunction

    static function automatic bit is_neg(logic [31:0] a);
      return !nan_bits(a) && a[30:0] != 0 && a[31];
    endfunction

    static function automatic logic [31:0] next_up(logic [31:0] b);
      if (b == roo_pkg::POS_INF) return b;
      if (b == roo_pkg::NEG_ZERO) b = 0;
      return b[31] ? b - 1 : b + 1;
    endfunction

    static function automatic logic [31:0] next_down(logic [31:0] b);
      if (b == roo_pkg::NEG_INF) return b;
      if (b == 0) b = roo_pkg::NEG_ZERO;
      return b[31] ? b + 1 : b - 1;
    endfunction

    static function automatic roo_pkg::out_req_t offset_origin(roo_pkg::in_req_t r);
      logic [31:0] pt[3], er[3], nm[3], dr[3], off[3], o[3];
      logic [31:0] acc, distance, facing;
      roo_pkg::out_req_t res;
      pt = '{r.point_x, r.point_y, r.point_z};
      er = '{r.err_x, r.err_y, r.err_z};
      nm = '{r.norm_x, r.norm_y, r.norm_z};
      dr = '{r.dir_x, r.dir_y, r.dir_z};
      acc = fmul({1'b0, nm[0][30:0]}, er[0]);
      acc = fadd(acc, fmul({1'b0, nm[1][30:0]}, er[1]));
      acc = fadd(acc, fmul({1'b0, nm[2][30:0]}, er[2]));
      distance = fmul(roo_pkg::FP_TWO, acc);
      acc = fmul(nm[0], dr[0]);
      acc = fadd(acc, fmul(nm[1], dr[1]));
      facing = fadd(acc, fmul(nm[2], dr[2]));
      for (int i = 0; i < 3; i++) begin
        off[i] = fmul(distance, nm[i]);
        if (is_neg(facing)) off[i][31] = ~off[i][31];
        o[i] = fadd(pt[i], off[i]);
        if (nan_bits(o[i])) o[i] = roo_pkg::QNAN;
        else if (is_pos(off[i])) o[i] = next_up(o[i]);
        else if (is_neg(off[i])) o[i] = next_down(o[i]);
      end
      res.origin_x = o[0];
      res.origin_y = o[1];
      res.origin_z = o[2];
      return res;
    endfunction

    function void note_request(roo_pkg::in_req_t r);
      pending.push_back(offset_origin(r));
    endfunction

    function void check_origin(roo_pkg::out_req_t got);
      roo_pkg::out_req_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected origin %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.origin_x !== want.origin_x || got.origin_y !== want.origin_y ||
          got.origin_z !== want.origin_z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("origin mismatch: expected %h %h %h, got %h %h %h",
                   want.origin_x, want.origin_y, want.origin_z,
                   got.origin_x, got.origin_y, got.origin_z);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  roo_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_stall;
  roo_pkg::out_req_t out_data;
  bit                sending_done;
  origin_board       board;

  ray_origin_offset u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draw a gap; every so often switch to a stretch with no gaps
  function automatic int draw_gap(ref bit quiet);
    if ($urandom_range(0, 63) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  // Present one request, hold it until taken, then note it
  task automatic send_request(roo_pkg::in_req_t r, ref bit quiet);
    int gap;
    gap = draw_gap(quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  // Mostly realistic magnitudes, with occasional raw patterns and specials
  function automatic logic [31:0] pick_float(int lo_exp, int hi_exp);
    case ($urandom_range(0, 19))
      0, 1: return $urandom;
      2: return {1'($urandom), 31'd0};
      3: return {1'($urandom), 8'd0, 23'($urandom)};
      4: return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? 0 : $urandom)};
      5: return {1'($urandom), FLT_MAX[30:0]};
      default: return {1'($urandom), 8'($urandom_range(lo_exp, hi_exp)), 23'($urandom)};
    endcase
  endfunction

  function automatic roo_pkg::in_req_t pick_request();
    roo_pkg::in_req_t r;
    int pe;
    pe = $urandom_range(100, 150);
    r.point_x = pick_float(pe - 10, pe + 10);
    r.point_y = pick_float(pe - 10, pe + 10);
    r.point_z = pick_float(pe - 10, pe + 10);
    r.err_x = pick_float(pe - 30, pe - 15) & 32'h7FFF_FFFF;
    r.err_y = pick_float(pe - 30, pe - 15) & 32'h7FFF_FFFF;
    r.err_z = pick_float(pe - 30, pe - 15) & 32'h7FFF_FFFF;
    if ($urandom_range(0, 9) == 0) r.err_x = $urandom;
    r.norm_x = pick_float(120, 127);
    r.norm_y = pick_float(120, 127);
    r.norm_z = pick_float(120, 127);
    r.dir_x = pick_float(120, 127);
    r.dir_y = pick_float(120, 127);
    r.dir_z = pick_float(120, 127);
    return r;
  endfunction

  function automatic roo_pkg::in_req_t make_request(logic [31:0] p, logic [31:0] e,
                                                    logic [31:0] n, logic [31:0] d);
    roo_pkg::in_req_t r;
    r = '{p, p, p, e, e, e, n, 32'h0, 32'h0, d, 32'h0, 32'h0};
    return r;
  endfunction

  // Drive requests: corner cases first, then random traffic
  initial begin
    roo_pkg::in_req_t corner[$];
    bit quiet;
    board = new();
    quiet = 0;
    sending_done = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    corner.push_back(make_request(ONE_F, 32'h3400_0000, ONE_F, ONE_F));
    corner.push_back(make_request(ONE_F, 32'h3400_0000, ONE_F, NEG_ONE));
    corner.push_back(make_request(ONE_F, 32'h3400_0000, 32'h0, ONE_F));
    corner.push_back(make_request(32'h0, MIN_SUB, ONE_F, ONE_F));
    corner.push_back(make_request(roo_pkg::NEG_ZERO, MIN_SUB, ONE_F, NEG_ONE));
    corner.push_back(make_request(roo_pkg::NEG_ZERO, 32'h0, ONE_F, ONE_F));
    corner.push_back(make_request(roo_pkg::POS_INF, ONE_F, ONE_F, NEG_ONE));
    corner.push_back(make_request(roo_pkg::NEG_INF, ONE_F, ONE_F, ONE_F));
    corner.push_back(make_request(roo_pkg::POS_INF, ONE_F, ONE_F, ONE_F));
    corner.push_back(make_request(roo_pkg::NEG_INF, ONE_F, ONE_F, NEG_ONE));
    corner.push_back(make_request(FLT_MAX, FLT_MAX, ONE_F, ONE_F));
    corner.push_back(make_request(ONE_F, 32'h3400_0000, SNAN, ONE_F));
    corner.push_back(make_request(ONE_F, 32'h3400_0000, ONE_F, roo_pkg::QNAN));
    corner.push_back(make_request(ONE_F, 32'h3400_0000, roo_pkg::POS_INF, 32'h0));
    corner.push_back(make_request(ONE_F, roo_pkg::POS_INF, 32'h0, ONE_F));
    corner.push_back(make_request(roo_pkg::QNAN, ONE_F, ONE_F, ONE_F));
    corner.push_back(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF));
    corner.push_back(make_request(32'h807F_FFFF, MIN_SUB, NEG_ONE, ONE_F));
    corner.push_back(make_request(32'h007F_FFFF, MIN_SUB, ONE_F, ONE_F));
    corner.push_back('{default: 32'h0});
    foreach (corner[i]) send_request(corner[i], quiet);
    repeat (N_RANDOM) send_request(pick_request(), quiet);
    in_valid <= 1'b0;
    sending_done = 1;
  end

  // Result side back-pressure: hold stall for a drawn gap
  initial begin
    bit quiet;
    int gap;
    quiet = 0;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap(quiet);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Score each result as it is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_origin(out_data);
  end

  // Drain and report
  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("ray_origin_offset_test OK");
    else $display("ray_origin_offset_test NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("ray_origin_offset_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/roo_pkg.sv
rtl/roo_prod_lane.sv
rtl/roo_merge.sv
rtl/roo_out_lane.sv
rtl/ray_origin_offset.sv
sim/ray_origin_offset_test.sv
